// File: rtl/core/touch_gesture_classifier_macros.svh
// ----------------------------------------------------------------------------
// Touch gesture classifier assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define TGC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("touch gesture classifier: same-cycle check failed");

// next-cycle implication
`define TGC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("touch gesture classifier: next-cycle check failed");

`endif

// File: rtl/core/tgc_pkg.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier package
// Beat types, gesture codes and helper functions shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgc_pkg;

   localparam int COORD_BITS   = 12;
   localparam int COUNT_BITS   = 3;
   localparam int THR_BITS     = 12;
   localparam int GESTURE_BITS = 4;
   localparam int DELTA_BITS   = COORD_BITS + 1;

   localparam logic [THR_BITS-1:0]   THR_RESET = THR_BITS'(20);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);

   typedef enum logic [GESTURE_BITS-1:0] {
      G_NONE     = 4'd0,
      G_TOUCH    = 4'd1,
      G_RIGHT    = 4'd2,
      G_LEFT     = 4'd3,
      G_DOWN     = 4'd4,
      G_UP       = 4'd5,
      G_SPREAD_X = 4'd6,
      G_PINCH_X  = 4'd7,
      G_SPREAD_Y = 4'd8,
      G_PINCH_Y  = 4'd9
   } gesture_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] touch_count;
      logic [COORD_BITS-1:0] first_x;
      logic [COORD_BITS-1:0] first_y;
      logic [COORD_BITS-1:0] second_x;
      logic [COORD_BITS-1:0] second_y;
   } req_type;

   typedef struct packed {
      gesture_type           gesture;
      logic [COORD_BITS-1:0] report_x;
      logic [COORD_BITS-1:0] report_y;
   } rsp_type;

   typedef struct packed {
      logic signed [DELTA_BITS-1:0] dx;
      logic signed [DELTA_BITS-1:0] dy;
   } delta_type;

   function automatic logic [COORD_BITS-1:0] abs_diff(
      input logic [COORD_BITS-1:0] a,
      input logic [COORD_BITS-1:0] b
   );
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [COORD_BITS-1:0] magnitude(
      input logic signed [DELTA_BITS-1:0] v
   );
      logic signed [DELTA_BITS-1:0] neg;
      neg = -v;
      magnitude = v[DELTA_BITS-1] ? neg[COORD_BITS-1:0] : v[COORD_BITS-1:0];
   endfunction

endpackage

// File: rtl/core/touch_gesture_classifier.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier
// Compares each touch frame with the previous one and returns a gesture code
// with the first point's coordinates.
//
//   channel   direction   handshake                  payload
//   req       in          req_valid / req_stall      req_data (tgc_pkg::req_type)
//   rsp       out         rsp_valid / rsp_stall      rsp_data (tgc_pkg::rsp_type)
//   csr       in          csr_write_enable           csr_write_data (threshold)
//
// One beat per cycle while the result is not stalled; a beat passes the input
// register, then the result register, and the decision logic sits between them.
// The previous frame is updated as a beat moves from the input register to
// the result register. Reset clears it to zero and sets the threshold to 20.
// A stall holds each full register; req_stall rises only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "touch_gesture_classifier_macros.svh"

module touch_gesture_classifier (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tgc_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tgc_pkg::rsp_type             rsp_data,
   input  logic                         csr_write_enable,
   input  logic [tgc_pkg::THR_BITS-1:0] csr_write_data
);

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   tgc_pkg::req_type             s1_frame_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   tgc_pkg::rsp_type             rsp_data_ff;
   tgc_pkg::req_type             last_frame_ff;
   logic [tgc_pkg::THR_BITS-1:0] threshold_ff;
   logic [tgc_pkg::THR_BITS-1:0] threshold_in;

   logic                 s2_open;
   logic                 s1_fire;
   logic                 req_fire;
   tgc_pkg::delta_type   delta;
   tgc_pkg::gesture_type gesture;

   assign s2_open  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire  = s1_valid_ff && s2_open;
   assign req_stall = s1_valid_ff && !s2_open;
   assign req_fire = req_valid && !req_stall;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);
   assign threshold_in = csr_write_enable ? csr_write_data : threshold_ff;

   tgc_delta u_delta (
      .frame      (s1_frame_ff),
      .last_frame (last_frame_ff),
      .delta      (delta)
   );

   tgc_decide u_decide (
      .touch_count (s1_frame_ff.touch_count),
      .last_count  (last_frame_ff.touch_count),
      .delta       (delta),
      .threshold   (threshold_ff),
      .gesture     (gesture)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_frame_ff <= '0;
         threshold_ff  <= tgc_pkg::THR_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
         if (s1_fire) begin
            last_frame_ff <= s1_frame_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_frame_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff.gesture  <= gesture;
         rsp_data_ff.report_x <= s1_frame_ff.first_x;
         rsp_data_ff.report_y <= s1_frame_ff.first_y;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TGC_ASSERT_NOW(a_stall_only_when_full, req_stall, s1_valid_ff && rsp_valid_ff)
   `TGC_ASSERT_NEXT(a_advance_fills_result, s1_fire, rsp_valid_ff)
   `TGC_ASSERT_NEXT(a_last_frame_tracks, s1_fire, last_frame_ff == $past(s1_frame_ff))
   `TGC_ASSERT_NEXT(a_zero_count_none, s1_fire && (s1_frame_ff.touch_count == '0),
      rsp_data_ff.gesture == tgc_pkg::G_NONE)

endmodule

// File: rtl/core/tgc_delta.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier axis deltas
// Signed change per axis: span change for two touches, point motion otherwise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgc_delta (
   input  tgc_pkg::req_type   frame,
   input  tgc_pkg::req_type   last_frame,
   output tgc_pkg::delta_type delta
);

   logic signed [tgc_pkg::DELTA_BITS-1:0] move_dx;
   logic signed [tgc_pkg::DELTA_BITS-1:0] move_dy;
   logic signed [tgc_pkg::DELTA_BITS-1:0] span_dx;
   logic signed [tgc_pkg::DELTA_BITS-1:0] span_dy;

   assign move_dx = $signed({1'b0, frame.first_x}) - $signed({1'b0, last_frame.first_x});
   assign move_dy = $signed({1'b0, frame.first_y}) - $signed({1'b0, last_frame.first_y});

   assign span_dx =
      $signed({1'b0, tgc_pkg::abs_diff(frame.second_x, frame.first_x)}) -
      $signed({1'b0, tgc_pkg::abs_diff(last_frame.second_x, last_frame.first_x)});
   assign span_dy =
      $signed({1'b0, tgc_pkg::abs_diff(frame.second_y, frame.first_y)}) -
      $signed({1'b0, tgc_pkg::abs_diff(last_frame.second_y, last_frame.first_y)});

   always_comb begin
      if (frame.touch_count == tgc_pkg::COUNT_TWO) begin
         delta.dx = span_dx;
         delta.dy = span_dy;
      end else begin
         delta.dx = move_dx;
         delta.dy = move_dy;
      end
   end

endmodule

// File: rtl/core/tgc_decide.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier decision
// Count checks, dominant axis, inertia threshold and gesture code select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgc_decide (
   input  logic [tgc_pkg::COUNT_BITS-1:0] touch_count,
   input  logic [tgc_pkg::COUNT_BITS-1:0] last_count,
   input  tgc_pkg::delta_type             delta,
   input  logic [tgc_pkg::THR_BITS-1:0]   threshold,
   output tgc_pkg::gesture_type           gesture
);

   logic [tgc_pkg::COORD_BITS-1:0] ax;
   logic [tgc_pkg::COORD_BITS-1:0] ay;
   logic                           x_rules;
   logic                           below;
   logic                           positive;
   logic                           two_point;

   assign ax        = tgc_pkg::magnitude(delta.dx);
   assign ay        = tgc_pkg::magnitude(delta.dy);
   assign x_rules   = ax > ay;
   assign two_point = touch_count == tgc_pkg::COUNT_TWO;

   always_comb begin
      if (x_rules) begin
         below    = ax < threshold;
         positive = !delta.dx[tgc_pkg::DELTA_BITS-1] && (delta.dx != '0);
      end else begin
         below    = ay < threshold;
         positive = !delta.dy[tgc_pkg::DELTA_BITS-1] && (delta.dy != '0);
      end
   end

   always_comb begin
      priority if (touch_count == '0) begin
         gesture = tgc_pkg::G_NONE;
      end else if (touch_count != last_count) begin
         gesture = tgc_pkg::G_TOUCH;
      end else if (touch_count != tgc_pkg::COUNT_ONE && !two_point) begin
         gesture = tgc_pkg::G_NONE;
      end else if (below) begin
         gesture = tgc_pkg::G_TOUCH;
      end else if (two_point) begin
         if (x_rules) begin
            gesture = positive ? tgc_pkg::G_SPREAD_X : tgc_pkg::G_PINCH_X;
         end else begin
            gesture = positive ? tgc_pkg::G_SPREAD_Y : tgc_pkg::G_PINCH_Y;
         end
      end else begin
         if (x_rules) begin
            gesture = positive ? tgc_pkg::G_RIGHT : tgc_pkg::G_LEFT;
         end else begin
            gesture = positive ? tgc_pkg::G_DOWN : tgc_pkg::G_UP;
         end
      end
   end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Touch gesture classifier testbench
// Sends touch frames through the req channel and checks each gesture report
// against an in-bench predictor that tracks the previous frame and threshold.
// A directed table covers the field extremes, every gesture code and the
// threshold edges. Random phases follow, each at its own threshold, with a mix
// of sender gaps and receiver stalls, and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int ITEMS_PER_PHASE = 300;
   localparam int PHASES          = 6;
   localparam int HOLD_CYCLES     = 300;
   localparam int MAX_GAP         = 40;
   localparam int DRAIN_CYCLES    = 4;
   localparam int STALL_LIMIT     = 3000;

   typedef struct packed {
      logic                         cfg_en;
      logic [tgc_pkg::THR_BITS-1:0] cfg_val;
      tgc_pkg::req_type             frame;
      logic                         typed;
      tgc_pkg::gesture_type         gest;
   } plan_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   tgc_pkg::req_type             req_data;
   logic                         rsp_valid;
   logic                         rsp_stall;
   tgc_pkg::rsp_type             rsp_data;
   logic                         csr_write_enable;
   logic [tgc_pkg::THR_BITS-1:0] csr_write_data;

   // predictor state
   logic [tgc_pkg::THR_BITS-1:0]   cur_threshold;
   logic [tgc_pkg::COUNT_BITS-1:0] prev_count;
   logic [tgc_pkg::COORD_BITS-1:0] prev_fx, prev_fy, prev_sx, prev_sy;

   tgc_pkg::rsp_type expected_reports[$];
   plan_row_type     directed_pending[$];

   int frames_sent;
   int reports_checked;
   int mismatches;
   int quiet_cycles;
   int send_idle_pct;
   int stall_pct;
   int hold_count;
   logic hold_request;

   // random frame generator state
   logic [tgc_pkg::COUNT_BITS-1:0] gen_count;
   logic [tgc_pkg::COORD_BITS-1:0] gen_fx, gen_fy, gen_sx, gen_sy;
   int run_left;

   plan_row_type directed_plan [0:30] = '{
      '{0, 0,    '{0, 4095, 4095, 4095, 4095}, 1, tgc_pkg::G_NONE},
      '{0, 0,    '{1, 0, 0, 0, 0},             1, tgc_pkg::G_TOUCH},
      '{0, 0,    '{1, 4095, 0, 0, 0},          1, tgc_pkg::G_RIGHT},
      '{0, 0,    '{1, 0, 0, 0, 0},             1, tgc_pkg::G_LEFT},
      '{0, 0,    '{1, 0, 4095, 0, 0},          1, tgc_pkg::G_DOWN},
      '{0, 0,    '{1, 0, 0, 4095, 4095},       1, tgc_pkg::G_UP},
      '{0, 0,    '{1, 10, 5, 0, 0},            0, tgc_pkg::G_NONE},
      '{0, 0,    '{1, 30, 5, 0, 0},            0, tgc_pkg::G_NONE},
      '{0, 0,    '{1, 30, 24, 0, 0},           0, tgc_pkg::G_NONE},
      '{0, 0,    '{1, 60, 54, 0, 0},           0, tgc_pkg::G_NONE},
      '{0, 0,    '{2, 0, 0, 0, 0},             1, tgc_pkg::G_TOUCH},
      '{0, 0,    '{2, 0, 0, 4095, 0},          1, tgc_pkg::G_SPREAD_X},
      '{0, 0,    '{2, 4095, 0, 4095, 0},       1, tgc_pkg::G_PINCH_X},
      '{0, 0,    '{2, 0, 0, 0, 4095},          1, tgc_pkg::G_SPREAD_Y},
      '{0, 0,    '{2, 0, 4095, 0, 4095},       1, tgc_pkg::G_PINCH_Y},
      '{0, 0,    '{2, 100, 100, 90, 130},      0, tgc_pkg::G_NONE},
      '{0, 0,    '{2, 100, 100, 75, 120},      0, tgc_pkg::G_NONE},
      '{0, 0,    '{3, 1, 2, 3, 4},             1, tgc_pkg::G_TOUCH},
      '{0, 0,    '{3, 5, 6, 7, 8},             1, tgc_pkg::G_NONE},
      '{0, 0,    '{5, 4095, 4095, 4095, 4095}, 1, tgc_pkg::G_TOUCH},
      '{0, 0,    '{5, 0, 0, 0, 0},             1, tgc_pkg::G_NONE},
      '{0, 0,    '{6, 11, 22, 33, 44},         1, tgc_pkg::G_TOUCH},
      '{0, 0,    '{7, 2730, 1365, 2730, 1365}, 1, tgc_pkg::G_TOUCH},
      '{0, 0,    '{7, 1365, 2730, 1365, 2730}, 1, tgc_pkg::G_NONE},
      '{0, 0,    '{0, 0, 0, 0, 0},             1, tgc_pkg::G_NONE},
      '{1, 0,    '{1, 7, 9, 0, 0},             1, tgc_pkg::G_TOUCH},
      '{0, 0,    '{1, 7, 9, 0, 0},             1, tgc_pkg::G_UP},
      '{0, 0,    '{2, 7, 9, 7, 9},             1, tgc_pkg::G_TOUCH},
      '{0, 0,    '{2, 7, 9, 7, 9},             1, tgc_pkg::G_PINCH_Y},
      '{1, 4095, '{2, 0, 0, 0, 0},             1, tgc_pkg::G_TOUCH},
      '{0, 0,    '{2, 0, 0, 4095, 0},          1, tgc_pkg::G_SPREAD_X}
   };

   touch_gesture_classifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int magnitude_of(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // dominant axis decides; ties go to y
   function automatic tgc_pkg::gesture_type classify_motion(input int dx, input int dy,
         input tgc_pkg::gesture_type pos_x, input tgc_pkg::gesture_type neg_x,
         input tgc_pkg::gesture_type pos_y, input tgc_pkg::gesture_type neg_y);
      int ax;
      int ay;
      int thr;
      ax  = magnitude_of(dx);
      ay  = magnitude_of(dy);
      thr = int'(cur_threshold);
      if (ax > ay) begin
         if (ax < thr) return tgc_pkg::G_TOUCH;
         return (dx > 0) ? pos_x : neg_x;
      end
      if (ay < thr) return tgc_pkg::G_TOUCH;
      return (dy > 0) ? pos_y : neg_y;
   endfunction

   function automatic tgc_pkg::rsp_type predict_report(input tgc_pkg::req_type f);
      tgc_pkg::rsp_type r;
      int span_dx;
      int span_dy;
      r.report_x = f.first_x;
      r.report_y = f.first_y;
      if (f.touch_count == '0) begin
         r.gesture = tgc_pkg::G_NONE;
      end else if (f.touch_count != prev_count) begin
         r.gesture = tgc_pkg::G_TOUCH;
      end else if (f.touch_count == tgc_pkg::COUNT_ONE) begin
         r.gesture = classify_motion(int'(f.first_x) - int'(prev_fx),
                                     int'(f.first_y) - int'(prev_fy),
                                     tgc_pkg::G_RIGHT, tgc_pkg::G_LEFT,
                                     tgc_pkg::G_DOWN, tgc_pkg::G_UP);
      end else if (f.touch_count == tgc_pkg::COUNT_TWO) begin
         span_dx = magnitude_of(int'(f.second_x) - int'(f.first_x))
                 - magnitude_of(int'(prev_sx) - int'(prev_fx));
         span_dy = magnitude_of(int'(f.second_y) - int'(f.first_y))
                 - magnitude_of(int'(prev_sy) - int'(prev_fy));
         r.gesture = classify_motion(span_dx, span_dy,
                                     tgc_pkg::G_SPREAD_X, tgc_pkg::G_PINCH_X,
                                     tgc_pkg::G_SPREAD_Y, tgc_pkg::G_PINCH_Y);
      end else begin
         r.gesture = tgc_pkg::G_NONE;
      end
      return r;
   endfunction

   // accept tracking and report checking
   always @(posedge clock) begin
      tgc_pkg::rsp_type want;
      plan_row_type row;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = predict_report(req_data);
            if (directed_pending.size() != 0) begin
               row = directed_pending.pop_front();
               if (row.typed) want.gesture = row.gest;
            end
            expected_reports.push_back(want);
            prev_count  = req_data.touch_count;
            prev_fx     = req_data.first_x;
            prev_fy     = req_data.first_y;
            prev_sx     = req_data.second_x;
            prev_sy     = req_data.second_y;
            frames_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected report beat: gesture %0d x %0d y %0d",
                      rsp_data.gesture, rsp_data.report_x, rsp_data.report_y);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_data.gesture !== want.gesture) begin
                  $error("gesture: expected %0d, got %0d", want.gesture, rsp_data.gesture);
                  mismatches++;
               end
               if (rsp_data.report_x !== want.report_x) begin
                  $error("report_x: expected %0d, got %0d", want.report_x,
                         rsp_data.report_x);
                  mismatches++;
               end
               if (rsp_data.report_y !== want.report_y) begin
                  $error("report_y: expected %0d, got %0d", want.report_y,
                         rsp_data.report_y);
                  mismatches++;
               end
               reports_checked++;
            end
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stall, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            hold_count++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_frame(input tgc_pkg::req_type f);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic set_threshold(input logic [tgc_pkg::THR_BITS-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      cur_threshold    = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly steady runs of one or two points moving near the threshold
   function automatic tgc_pkg::req_type next_frame();
      tgc_pkg::req_type f;
      int reach;
      int pick;
      if (run_left == 0) begin
         pick = $urandom_range(99);
         if (pick < 40)      gen_count = tgc_pkg::COUNT_ONE;
         else if (pick < 80) gen_count = tgc_pkg::COUNT_TWO;
         else if (pick < 88) gen_count = '0;
         else                gen_count = tgc_pkg::COUNT_BITS'($urandom_range(3, 7));
         run_left = $urandom_range(1, 10);
         if ($urandom_range(3) == 0) begin
            gen_fx = tgc_pkg::COORD_BITS'($urandom);
            gen_fy = tgc_pkg::COORD_BITS'($urandom);
            gen_sx = tgc_pkg::COORD_BITS'($urandom);
            gen_sy = tgc_pkg::COORD_BITS'($urandom);
         end
      end
      run_left--;
      reach = int'(cur_threshold) * 2 + 8;
      if (reach > 4095) reach = 4095;
      gen_fx = gen_fx + tgc_pkg::COORD_BITS'(int'($urandom_range(2 * reach)) - reach);
      gen_fy = gen_fy + tgc_pkg::COORD_BITS'(int'($urandom_range(2 * reach)) - reach);
      gen_sx = gen_sx + tgc_pkg::COORD_BITS'(int'($urandom_range(2 * reach)) - reach);
      gen_sy = gen_sy + tgc_pkg::COORD_BITS'(int'($urandom_range(2 * reach)) - reach);
      f.touch_count = gen_count;
      f.first_x     = gen_fx;
      f.first_y     = gen_fy;
      f.second_x    = gen_sx;
      f.second_y    = gen_sy;
      if ($urandom_range(19) == 0) begin
         f.touch_count = tgc_pkg::COUNT_BITS'($urandom_range(7));
      end
      if ($urandom_range(9) == 0) begin
         f.first_x  = tgc_pkg::COORD_BITS'($urandom);
         f.first_y  = tgc_pkg::COORD_BITS'($urandom);
         f.second_x = tgc_pkg::COORD_BITS'($urandom);
         f.second_y = tgc_pkg::COORD_BITS'($urandom);
      end
      return f;
   endfunction

   initial begin
      logic [tgc_pkg::THR_BITS-1:0] phase_thr;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      cur_threshold    = tgc_pkg::THR_RESET;
      prev_count       = '0;
      prev_fx          = '0;
      prev_fy          = '0;
      prev_sx          = '0;
      prev_sy          = '0;
      frames_sent      = 0;
      reports_checked  = 0;
      mismatches       = 0;
      quiet_cycles     = 0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      hold_count       = 0;
      hold_request     = 1'b0;
      gen_count        = '0;
      gen_fx           = '0;
      gen_fy           = '0;
      gen_sx           = '0;
      gen_sy           = '0;
      run_left         = 0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].cfg_en) set_threshold(directed_plan[i].cfg_val);
         directed_pending.push_back(directed_plan[i]);
         send_frame(directed_plan[i].frame);
      end

      for (int p = 0; p < PHASES; p++) begin
         unique case (p)
            0:       phase_thr = tgc_pkg::THR_RESET;
            1:       phase_thr = '0;
            2:       phase_thr = '1;
            3:       phase_thr = tgc_pkg::THR_BITS'($urandom_range(2, 200));
            4:       phase_thr = tgc_pkg::THR_BITS'(1);
            default: phase_thr = tgc_pkg::THR_BITS'($urandom_range(4000, 4094));
         endcase
         set_threshold(phase_thr);
         unique case (p % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 87; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 87; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         // long receiver hold-off while frames keep coming
         if (p == 4) hold_request = 1'b1;
         repeat (ITEMS_PER_PHASE) send_frame(next_frame());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d frames and %0d reports over %0d threshold settings",
               frames_sent, reports_checked, PHASES + 2);
      $display("idle and stall mixes per phase, %0d long receiver hold-off(s)", hold_count);
      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
